FILE: rtl/fr_pkg.sv
// shared constants and types for the fraction reduction block
`timescale 1ns / 1ps

package fr_pkg;

   // input term width and magnitude width of a valid (positive) term
   localparam int FR_WIDTH   = 64;
   localparam int FR_MAG_W   = FR_WIDTH - 1;
   localparam int FR_SHIFT_W = $clog2(FR_MAG_W);

   // result status codes
   localparam logic [1:0] FR_ST_OK       = 2'd0;
   localparam logic [1:0] FR_ST_DEN_ZERO = 2'd1;
   localparam logic [1:0] FR_ST_NOT_POS  = 2'd2;

   // top level control states
   typedef enum logic [2:0] {
      FR_IDLE,
      FR_GCD,
      FR_DIV_NUM,
      FR_DIV_DEN,
      FR_FINISH
   } fr_state_type;

endpackage

FILE: rtl/fraction_reduce_checked_top.sv
// top level: term checks, gcd and serial division control, result register
`timescale 1ns / 1ps

// Reduces a signed fraction to lowest terms. A zero denominator gives
// status 1; otherwise a numerator of zero or less or a negative denominator
// gives status 2; both reduced terms are zero on error. A valid pair goes
// through a binary gcd (one shift or subtract-and-shift per cycle) and then
// two restoring divisions on one shared divider. One item is worked at a
// time; the next item is taken as soon as the finished result moves into
// the output register, even if that result has not been taken yet.
module fraction_reduce_checked_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [fr_pkg::FR_WIDTH-1:0] req_numerator,
   input  logic signed [fr_pkg::FR_WIDTH-1:0] req_denominator,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fr_pkg::FR_MAG_W-1:0]     rsp_reduced_numerator,
   output logic [fr_pkg::FR_MAG_W-1:0]     rsp_reduced_denominator,
   output logic [1:0]                      rsp_status
);

   fr_pkg::fr_state_type state_ff, state_in;

   logic [fr_pkg::FR_MAG_W-1:0] num_ff, num_in;
   logic [fr_pkg::FR_MAG_W-1:0] den_ff, den_in;
   logic [fr_pkg::FR_MAG_W-1:0] quo_num_ff, quo_num_in;
   logic [fr_pkg::FR_MAG_W-1:0] quo_den_ff, quo_den_in;
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fr_pkg::FR_MAG_W-1:0] rsp_num_ff, rsp_num_in;
   logic [fr_pkg::FR_MAG_W-1:0] rsp_den_ff, rsp_den_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   logic                        req_transfer;
   logic [1:0]                  check_status;
   logic                        gcd_start, gcd_done;
   logic [fr_pkg::FR_MAG_W-1:0] gcd_value;
   logic                        div_start, div_done;
   logic [fr_pkg::FR_MAG_W-1:0] div_dividend, div_quotient;
   logic                        slot_free;
   logic                        rsp_load;

   assign req_transfer = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;

   // term checks, zero denominator has priority
   always_comb begin
      if (req_denominator == '0) begin
         check_status = fr_pkg::FR_ST_DEN_ZERO;
      end else if (req_numerator == '0 || req_numerator[fr_pkg::FR_WIDTH-1] ||
                   req_denominator[fr_pkg::FR_WIDTH-1]) begin
         check_status = fr_pkg::FR_ST_NOT_POS;
      end else begin
         check_status = fr_pkg::FR_ST_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fr_pkg::FR_IDLE: begin
            if (req_transfer) begin
               state_in = (check_status == fr_pkg::FR_ST_OK) ? fr_pkg::FR_GCD
                                                             : fr_pkg::FR_FINISH;
            end
         end
         fr_pkg::FR_GCD: begin
            if (gcd_done) state_in = fr_pkg::FR_DIV_NUM;
         end
         fr_pkg::FR_DIV_NUM: begin
            if (div_done) state_in = fr_pkg::FR_DIV_DEN;
         end
         fr_pkg::FR_DIV_DEN: begin
            if (div_done) state_in = fr_pkg::FR_FINISH;
         end
         fr_pkg::FR_FINISH: begin
            if (slot_free) state_in = fr_pkg::FR_IDLE;
         end
         default: state_in = fr_pkg::FR_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready    = 1'b0;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = den_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         fr_pkg::FR_IDLE: begin
            req_ready = 1'b1;
            gcd_start = req_valid && (check_status == fr_pkg::FR_ST_OK);
         end
         fr_pkg::FR_GCD: begin
            div_start    = gcd_done;
            div_dividend = num_ff;
         end
         fr_pkg::FR_DIV_NUM: begin
            div_start = div_done;
         end
         fr_pkg::FR_FINISH: begin
            rsp_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // working registers
   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      quo_num_in = quo_num_ff;
      quo_den_in = quo_den_ff;
      status_in  = status_ff;
      if (req_transfer) begin
         num_in     = req_numerator[fr_pkg::FR_MAG_W-1:0];
         den_in     = req_denominator[fr_pkg::FR_MAG_W-1:0];
         quo_num_in = '0;
         quo_den_in = '0;
         status_in  = check_status;
      end
      if (div_done && state_ff == fr_pkg::FR_DIV_NUM) quo_num_in = div_quotient;
      if (div_done && state_ff == fr_pkg::FR_DIV_DEN) quo_den_in = div_quotient;
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_num_in    = quo_num_ff;
         rsp_den_in    = quo_den_ff;
         rsp_status_in = status_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      den_ff        <= den_in;
      quo_num_ff    <= quo_num_in;
      quo_den_ff    <= quo_den_in;
      status_ff     <= status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fr_pkg::FR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // gcd of the two positive terms
   fr_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (req_numerator[fr_pkg::FR_MAG_W-1:0]),
      .b     (req_denominator[fr_pkg::FR_MAG_W-1:0]),
      .done  (gcd_done),
      .gcd   (gcd_value)
   );

   // shared divider, numerator first then denominator
   fr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_done ? gcd_value : gcd_value),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_reduced_numerator   = rsp_num_ff;
   assign rsp_reduced_denominator = rsp_den_ff;
   assign rsp_status              = rsp_status_ff;

endmodule

FILE: rtl/fr_gcd.sv
// iterative binary gcd of two positive terms
`timescale 1ns / 1ps

module fr_gcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fr_pkg::FR_MAG_W-1:0]     a,
   input  logic [fr_pkg::FR_MAG_W-1:0]     b,
   output logic                            done,
   output logic [fr_pkg::FR_MAG_W-1:0]     gcd
);

   logic [fr_pkg::FR_MAG_W-1:0]   a_ff, a_in;
   logic [fr_pkg::FR_MAG_W-1:0]   b_ff, b_in;
   logic [fr_pkg::FR_SHIFT_W-1:0] k_ff, k_in;
   logic [fr_pkg::FR_MAG_W-1:0]   g_ff, g_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fr_pkg::FR_MAG_W:0]     diff_ab;
   logic [fr_pkg::FR_MAG_W-1:0]   diff_ba;

   // one subtract each way, sign of a-b gives the compare
   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = b_ff - a_ff;

   // one reduction step per cycle
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == b_ff) begin
            // restore the common factors of two
            g_in    = a_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (!diff_ab[fr_pkg::FR_MAG_W]) begin
            a_in = diff_ab[fr_pkg::FR_MAG_W-1:0] >> 1;
         end else begin
            b_in = diff_ba >> 1;
         end
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign gcd  = g_ff;

endmodule

FILE: rtl/fr_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fr_pkg::FR_MAG_W-1:0]     dividend,
   input  logic [fr_pkg::FR_MAG_W-1:0]     divisor,
   output logic                            done,
   output logic [fr_pkg::FR_MAG_W-1:0]     quotient
);

   localparam logic [fr_pkg::FR_SHIFT_W-1:0] LAST_BIT =
      fr_pkg::FR_SHIFT_W'(fr_pkg::FR_MAG_W - 1);

   logic [fr_pkg::FR_MAG_W-1:0]   quo_ff, quo_in;
   logic [fr_pkg::FR_MAG_W-1:0]   rem_ff, rem_in;
   logic [fr_pkg::FR_MAG_W-1:0]   dsr_ff, dsr_in;
   logic [fr_pkg::FR_SHIFT_W-1:0] count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fr_pkg::FR_MAG_W:0]     rem_sh;
   logic [fr_pkg::FR_MAG_W+1:0]   trial;

   // shift the next dividend bit into the partial remainder
   assign rem_sh = {rem_ff, quo_ff[fr_pkg::FR_MAG_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dsr_ff};

   // one trial subtract per cycle
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial[fr_pkg::FR_MAG_W+1]) begin
            rem_in = rem_sh[fr_pkg::FR_MAG_W-1:0];
            quo_in = {quo_ff[fr_pkg::FR_MAG_W-2:0], 1'b0};
         end else begin
            rem_in = trial[fr_pkg::FR_MAG_W-1:0];
            quo_in = {quo_ff[fr_pkg::FR_MAG_W-2:0], 1'b1};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: tb/sv/tb_fraction_reduce_checked_top.sv
// testbench for the fraction reduction block: directed table, random pairs, scoreboard
`timescale 1ns / 1ps

module tb_fraction_reduce_checked_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int DIRECTED_ROWS = 23;

   localparam logic [fr_pkg::FR_WIDTH-1:0] MOST_NEG =
      {1'b1, {(fr_pkg::FR_WIDTH-1){1'b0}}};
   localparam logic [fr_pkg::FR_WIDTH-1:0] MOST_POS =
      {1'b0, {(fr_pkg::FR_WIDTH-1){1'b1}}};
   localparam logic [fr_pkg::FR_WIDTH-1:0] ALL_ONES = {fr_pkg::FR_WIDTH{1'b1}};
   localparam logic [fr_pkg::FR_MAG_W-1:0] MAG_MAX  = {fr_pkg::FR_MAG_W{1'b1}};

   // one result of the block
   typedef struct packed {
      logic [fr_pkg::FR_MAG_W-1:0] num;
      logic [fr_pkg::FR_MAG_W-1:0] den;
      logic [1:0]                  status;
   } fraction_type;

   // directed row: operands, and a typed-in answer where it is obvious
   typedef struct packed {
      logic [fr_pkg::FR_WIDTH-1:0] num;
      logic [fr_pkg::FR_WIDTH-1:0] den;
      bit                          typed;
      fraction_type                answer;
   } fraction_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [fr_pkg::FR_WIDTH-1:0] req_numerator = '0;
   logic signed [fr_pkg::FR_WIDTH-1:0] req_denominator = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [fr_pkg::FR_MAG_W-1:0]        rsp_reduced_numerator;
   logic [fr_pkg::FR_MAG_W-1:0]        rsp_reduced_denominator;
   logic [1:0]                         rsp_status;

   fraction_type pending_fractions[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 29;
   int           recv_idle_pct = 50;

   fraction_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // zero denominator wins over every other check
      '{64'd0,    64'd0,    1'b1, '{'0, '0, fr_pkg::FR_ST_DEN_ZERO}},
      '{ALL_ONES, 64'd0,    1'b1, '{'0, '0, fr_pkg::FR_ST_DEN_ZERO}},
      '{MOST_NEG, 64'd0,    1'b1, '{'0, '0, fr_pkg::FR_ST_DEN_ZERO}},
      '{MOST_POS, 64'd0,    1'b1, '{'0, '0, fr_pkg::FR_ST_DEN_ZERO}},
      // non-positive terms, most negative value included
      '{64'd0,    64'd1,    1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{ALL_ONES, 64'd1,    1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{MOST_NEG, MOST_POS, 1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{64'd1,    ALL_ONES, 1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{MOST_POS, MOST_NEG, 1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{MOST_NEG, MOST_NEG, 1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      '{64'd0,    MOST_NEG, 1'b1, '{'0, '0, fr_pkg::FR_ST_NOT_POS}},
      // extremes of valid terms
      '{64'd1,    64'd1,    1'b1, '{63'd1, 63'd1, fr_pkg::FR_ST_OK}},
      '{MOST_POS, MOST_POS, 1'b1, '{63'd1, 63'd1, fr_pkg::FR_ST_OK}},
      '{MOST_POS, 64'd1,    1'b1, '{MAG_MAX, 63'd1, fr_pkg::FR_ST_OK}},
      '{64'd1,    MOST_POS, 1'b1, '{63'd1, MAG_MAX, fr_pkg::FR_ST_OK}},
      // the rest go through the predictor
      '{64'd12,   64'd18,   1'b0, '0},
      '{64'h4000_0000_0000_0000, 64'h10, 1'b0, '0},
      '{MOST_POS, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
      '{64'h7FFF_FFFF_FFFF_FFE7, 64'h7FFF_FFFF_FFFF_FF8D, 1'b0, '0},
      '{64'd7540113804746346429, 64'd4660046610375530309, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{64'd1000000, 64'd1000000000000, 1'b0, '0},
      '{64'd2,    64'd4,    1'b0, '0}
   };

   fraction_reduce_checked_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_numerator           (req_numerator),
      .req_denominator         (req_denominator),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_reduced_numerator   (rsp_reduced_numerator),
      .rsp_reduced_denominator (rsp_reduced_denominator),
      .rsp_status              (rsp_status)
   );

   // clock
   always #1 clock = ~clock;

   // expected result: checks first, then euclid and both divisions
   function automatic fraction_type reduce_fraction(logic [fr_pkg::FR_WIDTH-1:0] n,
                                                    logic [fr_pkg::FR_WIDTH-1:0] d);
      fraction_type      f;
      longint unsigned   a;
      longint unsigned   b;
      longint unsigned   r;
      f = '0;
      if (d == '0) begin
         f.status = fr_pkg::FR_ST_DEN_ZERO;
      end else if (n == '0 || n[fr_pkg::FR_WIDTH-1] || d[fr_pkg::FR_WIDTH-1]) begin
         f.status = fr_pkg::FR_ST_NOT_POS;
      end else begin
         a = n;
         b = d;
         while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
         end
         f.num    = fr_pkg::FR_MAG_W'(n / a);
         f.den    = fr_pkg::FR_MAG_W'(d / a);
         f.status = fr_pkg::FR_ST_OK;
      end
      return f;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // present one pair, hold it until the transfer, then queue its answer
   task automatic send_fraction(input logic [fr_pkg::FR_WIDTH-1:0] n,
                                input logic [fr_pkg::FR_WIDTH-1:0] d,
                                input bit typed, input fraction_type answer);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_numerator   = n;
      req_denominator = d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_fractions.push_back(typed ? answer : reduce_fraction(n, d));
      @(negedge clock);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fractions.size() == 0) begin
            $error("unexpected result: %0d/%0d status %0d",
                   rsp_reduced_numerator, rsp_reduced_denominator, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_reduced_numerator !== want.num) begin
               $error("reduced_numerator: expected %0d, got %0d",
                      want.num, rsp_reduced_numerator);
               mismatch_count++;
            end
            if (rsp_reduced_denominator !== want.den) begin
               $error("reduced_denominator: expected %0d, got %0d",
                      want.den, rsp_reduced_denominator);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [fr_pkg::FR_WIDTH-1:0] n;
      logic [fr_pkg::FR_WIDTH-1:0] d;
      logic [fr_pkg::FR_WIDTH-1:0] factor;
      int                          factor_w;
      int                          term_w;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_fraction(directed_rows[i].num, directed_rows[i].den,
                       directed_rows[i].typed, directed_rows[i].answer);

      // random pairs over three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 29; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // valid pair sharing a random factor
                  factor_w = $urandom_range(0, 40);
                  factor   = (factor_w == 0) ? 64'd1 : random_word() >> (64 - factor_w);
                  if (factor == '0) factor = 64'd1;
                  term_w = $urandom_range(1, 62 - factor_w);
                  n = random_word() >> (64 - term_w);
                  if (n == '0) n = 64'd1;
                  term_w = $urandom_range(1, 62 - factor_w);
                  d = random_word() >> (64 - term_w);
                  if (d == '0) d = 64'd1;
                  n = n * factor;
                  d = d * factor;
               end
               6, 7: begin
                  // non-negative terms of random size
                  n = random_word() >> $urandom_range(1, 63);
                  d = random_word() >> $urandom_range(1, 63);
               end
               8: begin
                  // raw noise, mostly rejected
                  n = random_word();
                  d = random_word();
               end
               default: begin
                  // zero or negative numerator, zero or random denominator
                  n = $urandom_range(0, 1) ? '0 : random_word() | MOST_NEG;
                  d = $urandom_range(0, 1) ? '0 : random_word();
               end
            endcase
            send_fraction(n, d, 1'b0, '0);
         end
      end
      req_valid = 1'b0;

      // drain, then give a stray result time to show up
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
